### rtl/ttsa_pkg.sv
package ttsa_pkg;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_NORMAL  = 2'd1,
      OP_TANGENT = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_LAT_C,
      ST_DELTA,
      ST_MUL1,
      ST_MUL2,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_ACC_RD,
      ST_ACC_LAT,
      ST_ACC_ADD,
      ST_DOT,
      ST_DOT_SUM,
      ST_ORTHO,
      ST_ORTHO_SUB,
      ST_ACC_WR,
      ST_EMIT_RD,
      ST_EMIT_LAT,
      ST_EMIT
   } state_type;

   localparam int WORD_W = 32;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                               inout logic flag);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7fffffff;
         flag = 1'b1;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
         flag = 1'b1;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### rtl/ttsa_divider.sv
module ttsa_divider #(
   parameter int FRACTION_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [31:0]  numer,
   input  logic signed [31:0]  denom,
   output logic                done,
   output logic signed [31:0]  quot,
   output logic                ovf
);
   localparam int NW = 32 + FRACTION_BITS;
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] rem_q_ff, rem_q_in;
   logic [32:0]   part_ff, part_in;
   logic [31:0]   dmag_ff, dmag_in;
   logic          neg_ff, neg_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in;
   logic          done_ff, done_in;
   logic [33:0]   trial;
   logic [NW:0]   qmag;

   always_comb begin
      rem_q_in = rem_q_ff;
      part_in  = part_ff;
      dmag_in  = dmag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      trial    = '0;
      if (start) begin
         rem_q_in = {(numer[31] ? 32'(-numer) : 32'(numer)), {FRACTION_BITS{1'b0}}};
         dmag_in  = denom[31] ? 32'(-denom) : 32'(denom);
         neg_in   = numer[31] ^ denom[31];
         part_in  = '0;
         cnt_in   = CW'(NW);
         run_in   = 1'b1;
      end else if (run_ff) begin
         trial = {part_ff, rem_q_ff[NW-1]} - {2'b00, dmag_ff};
         if (!trial[33]) begin
            part_in = trial[32:0];
         end else begin
            part_in = {part_ff[31:0], rem_q_ff[NW-1]};
         end
         rem_q_in = {rem_q_ff[NW-2:0], ~trial[33]};
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_q_ff <= rem_q_in;
      part_ff  <= part_in;
      dmag_ff  <= dmag_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_comb begin
      qmag = {1'b0, rem_q_ff};
      ovf  = 1'b0;
      quot = '0;
      if (neg_ff) begin
         if (qmag > (NW+1)'(33'h080000000)) begin
            ovf  = 1'b1;
            quot = 32'sh80000000;
         end else begin
            quot = 32'(-qmag);
         end
      end else begin
         if (qmag > (NW+1)'(33'h07fffffff)) begin
            ovf  = 1'b1;
            quot = 32'sh7fffffff;
         end else begin
            quot = qmag[31:0];
         end
      end
   end

   assign done = done_ff;

   ap_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held");
   ap_start_run: assert property (@(posedge clock) disable iff (reset)
      start |=> run_ff)
      else $error("divider not running");
   ap_idle_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("divider done while running");
endmodule

### rtl/triangle_tangent_space_accumulator.sv
// Vertex tangent-space accumulator. Accepts one command when start is high and
// busy is low; load and read give one result beat, normal and tangent commands
// give three (A, B, C) marked by rsp_valid, last one flagged by rsp_last_of_run.
// The receiver cannot stall. Vertex records sit in one memory with one write
// port and one read port, with registered read. A tangent command solves its
// six components one after another in the serial divider, unless the
// determinant is zero. Vertices never loaded read as undefined.
module triangle_tangent_space_accumulator #(
   parameter int VERTEX_COUNT  = 1024,
   parameter int FRACTION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [9:0]         req_index_a,
   input  logic [9:0]         req_index_b,
   input  logic [9:0]         req_index_c,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   input  logic signed [31:0] req_init_normal_x,
   input  logic signed [31:0] req_init_normal_y,
   input  logic signed [31:0] req_init_normal_z,
   output logic               rsp_valid,
   output logic [9:0]         rsp_vertex_id,
   output logic signed [31:0] rsp_tan_x,
   output logic signed [31:0] rsp_tan_y,
   output logic signed [31:0] rsp_tan_z,
   output logic signed [31:0] rsp_bitan_x,
   output logic signed [31:0] rsp_bitan_y,
   output logic signed [31:0] rsp_bitan_z,
   output logic signed [31:0] rsp_norm_x,
   output logic signed [31:0] rsp_norm_y,
   output logic signed [31:0] rsp_norm_z,
   output logic               rsp_degenerate,
   output logic               rsp_last_of_run
);
   localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
   localparam int RW = 32 * 14;

   // record: pos 0..2, tex 3..4, nrm 5..7, tan 8..10, bit 11..13
   typedef logic [RW-1:0] rec_type;
   typedef logic signed [31:0] vec3_type [3];

   rec_type mem [VERTEX_COUNT];
   rec_type rd_data_ff;
   logic           we;
   logic [AW-1:0]  waddr, raddr;
   rec_type        wdata;

   ttsa_pkg::state_type state_ff, state_in;
   ttsa_pkg::op_type    op_ff, op_in;
   logic [AW-1:0] idx_ff [3];
   logic [AW-1:0] idx_in [3];
   logic [1:0]    k_ff, k_in;
   logic [2:0]    j_ff, j_in;
   logic          flag_ff, flag_in;
   rec_type       ra_ff, rb_ff, rc_ff, cur_ff;
   rec_type       ra_in, rb_in, rc_in, cur_in;
   logic signed [31:0] p1_ff [3], p2_ff [3], p1_in [3], p2_in [3];
   logic signed [31:0] u1_ff, v1_ff, u2_ff, v2_ff, u1_in, v1_in, u2_in, v2_in;
   logic signed [31:0] det_ff, det_in;
   logic signed [31:0] acc_ff [6], acc_in [6];
   logic signed [63:0] pr_ff [6], pr_in [6];
   logic signed [31:0] dot_ff, dot_in;
   logic          side_ff, side_in;
   logic          div_start;
   logic signed [31:0] div_num;
   logic          div_done, div_ovf;
   logic signed [31:0] div_q;
   logic [AW-1:0] ld_idx;

   function automatic logic signed [31:0] fld(input rec_type r, input int i);
      return r[32*i +: 32];
   endfunction

   function automatic logic signed [65:0] fm(input logic signed [63:0] p);
      return 66'(p >>> FRACTION_BITS);
   endfunction

   function automatic logic [AW-1:0] red(input logic [9:0] v);
      logic [31:0] w;
      w = 32'(v) % VERTEX_COUNT;
      return w[AW-1:0];
   endfunction

   ttsa_divider #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (det_ff),
      .done  (div_done),
      .quot  (div_q),
      .ovf   (div_ovf)
   );

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_data_ff <= mem[raddr];
   end

   assign busy = (state_ff != ttsa_pkg::ST_IDLE);
   assign ld_idx = red(req_index_a);

   always_comb begin
      logic f;
      logic signed [31:0] t;
      logic signed [65:0] s;
      f = flag_ff;
      state_in = state_ff;
      op_in = op_ff;
      idx_in = idx_ff;
      k_in = k_ff;
      j_in = j_ff;
      ra_in = ra_ff; rb_in = rb_ff; rc_in = rc_ff; cur_in = cur_ff;
      p1_in = p1_ff; p2_in = p2_ff;
      u1_in = u1_ff; v1_in = v1_ff; u2_in = u2_ff; v2_in = v2_ff;
      det_in = det_ff;
      acc_in = acc_ff;
      pr_in = pr_ff;
      dot_in = dot_ff;
      side_in = side_ff;
      we = 1'b0;
      waddr = ld_idx;
      wdata = '0;
      raddr = idx_ff[k_ff];
      div_start = 1'b0;
      div_num = '0;
      rsp_valid = 1'b0;
      t = '0;
      s = '0;
      case (state_ff)
         ttsa_pkg::ST_IDLE: begin
            if (start) begin
               op_in = ttsa_pkg::op_type'(req_operation);
               idx_in[0] = ld_idx;
               idx_in[1] = red(req_index_b);
               idx_in[2] = red(req_index_c);
               f = 1'b0;
               k_in = '0;
               if (req_operation == ttsa_pkg::OP_LOAD) begin
                  we = 1'b1;
                  wdata = {32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                           req_init_normal_z, req_init_normal_y, req_init_normal_x,
                           req_tex_v, req_tex_u, req_pos_z, req_pos_y, req_pos_x};
                  state_in = ttsa_pkg::ST_EMIT_RD;
               end else if (req_operation == ttsa_pkg::OP_READ) begin
                  state_in = ttsa_pkg::ST_EMIT_RD;
               end else begin
                  state_in = ttsa_pkg::ST_RD_A;
               end
            end
         end
         ttsa_pkg::ST_RD_A: begin
            raddr = idx_ff[0];
            state_in = ttsa_pkg::ST_RD_B;
         end
         ttsa_pkg::ST_RD_B: begin
            raddr = idx_ff[1];
            ra_in = rd_data_ff;
            state_in = ttsa_pkg::ST_RD_C;
         end
         ttsa_pkg::ST_RD_C: begin
            raddr = idx_ff[2];
            rb_in = rd_data_ff;
            state_in = ttsa_pkg::ST_LAT_C;
         end
         ttsa_pkg::ST_LAT_C: begin
            rc_in = rd_data_ff;
            state_in = ttsa_pkg::ST_DELTA;
         end
         ttsa_pkg::ST_DELTA: begin
            for (int i = 0; i < 3; i++) begin
               p1_in[i] = ttsa_pkg::sat32(66'(fld(rb_ff, i)) - 66'(fld(ra_ff, i)), f);
               p2_in[i] = ttsa_pkg::sat32(66'(fld(rc_ff, i)) - 66'(fld(ra_ff, i)), f);
            end
            if (op_ff == ttsa_pkg::OP_TANGENT) begin
               u1_in = ttsa_pkg::sat32(66'(fld(rb_ff, 3)) - 66'(fld(ra_ff, 3)), f);
               v1_in = ttsa_pkg::sat32(66'(fld(rb_ff, 4)) - 66'(fld(ra_ff, 4)), f);
               u2_in = ttsa_pkg::sat32(66'(fld(rc_ff, 3)) - 66'(fld(ra_ff, 3)), f);
               v2_in = ttsa_pkg::sat32(66'(fld(rc_ff, 4)) - 66'(fld(ra_ff, 4)), f);
            end
            state_in = ttsa_pkg::ST_MUL1;
         end
         ttsa_pkg::ST_MUL1: begin
            if (op_ff == ttsa_pkg::OP_NORMAL) begin
               pr_in[0] = p2_ff[1] * p1_ff[2];
               pr_in[1] = p2_ff[2] * p1_ff[1];
               pr_in[2] = p2_ff[2] * p1_ff[0];
               pr_in[3] = p2_ff[0] * p1_ff[2];
               pr_in[4] = p2_ff[0] * p1_ff[1];
               pr_in[5] = p2_ff[1] * p1_ff[0];
            end else begin
               pr_in[0] = u1_ff * v2_ff;
               pr_in[1] = v1_ff * u2_ff;
            end
            state_in = ttsa_pkg::ST_MUL2;
         end
         ttsa_pkg::ST_MUL2: begin
            if (op_ff == ttsa_pkg::OP_NORMAL) begin
               for (int i = 0; i < 3; i++) begin
                  acc_in[i] = ttsa_pkg::sat32(fm(pr_ff[2*i]) - fm(pr_ff[2*i+1]), f);
               end
               k_in = '0;
               state_in = ttsa_pkg::ST_ACC_RD;
            end else begin
               det_in = ttsa_pkg::sat32(fm(pr_ff[0]) - fm(pr_ff[1]), f);
               j_in = '0;
               for (int i = 0; i < 6; i++) begin
                  acc_in[i] = '0;
               end
               state_in = ttsa_pkg::ST_DIV_START;
            end
         end
         ttsa_pkg::ST_DIV_START: begin
            if (det_ff == 0) begin
               f = 1'b1;
               k_in = '0;
               state_in = ttsa_pkg::ST_ACC_RD;
            end else begin
               // numerator for component j: j<3 tangent, else bitangent
               if (j_ff < 3'd3) begin
                  s = fm(p1_ff[j_ff[1:0]] * v2_ff) - fm(p2_ff[j_ff[1:0]] * v1_ff);
               end else begin
                  s = fm(p2_ff[2'(j_ff - 3'd3)] * u1_ff)
                      - fm(p1_ff[2'(j_ff - 3'd3)] * u2_ff);
               end
               div_num = ttsa_pkg::sat32(s, f);
               div_start = 1'b1;
               state_in = ttsa_pkg::ST_DIV_WAIT;
            end
         end
         ttsa_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               acc_in[j_ff] = div_q;
               if (div_ovf) begin
                  f = 1'b1;
               end
               if (j_ff == 3'd5) begin
                  k_in = '0;
                  state_in = ttsa_pkg::ST_ACC_RD;
               end else begin
                  j_in = j_ff + 3'd1;
                  state_in = ttsa_pkg::ST_DIV_START;
               end
            end
         end
         ttsa_pkg::ST_ACC_RD: begin
            state_in = ttsa_pkg::ST_ACC_LAT;
         end
         ttsa_pkg::ST_ACC_LAT: begin
            cur_in = rd_data_ff;
            state_in = ttsa_pkg::ST_ACC_ADD;
         end
         ttsa_pkg::ST_ACC_ADD: begin
            if (op_ff == ttsa_pkg::OP_NORMAL) begin
               for (int i = 0; i < 3; i++) begin
                  t = ttsa_pkg::sat32(66'(fld(cur_ff, 5+i)) + 66'(acc_ff[i]), f);
                  cur_in[32*(5+i) +: 32] = t;
               end
               state_in = ttsa_pkg::ST_ACC_WR;
            end else begin
               for (int i = 0; i < 6; i++) begin
                  t = ttsa_pkg::sat32(66'(fld(cur_ff, 8+i)) + 66'(acc_ff[i]), f);
                  cur_in[32*(8+i) +: 32] = t;
               end
               side_in = 1'b0;
               state_in = ttsa_pkg::ST_DOT;
            end
         end
         ttsa_pkg::ST_DOT: begin
            for (int i = 0; i < 3; i++) begin
               pr_in[i] = fld(cur_ff, 5+i)
                        * fld(cur_ff, (side_ff ? 11 : 8) + i);
            end
            state_in = ttsa_pkg::ST_DOT_SUM;
         end
         ttsa_pkg::ST_DOT_SUM: begin
            dot_in = ttsa_pkg::sat32(fm(pr_ff[0]) + fm(pr_ff[1]) + fm(pr_ff[2]), f);
            state_in = ttsa_pkg::ST_ORTHO;
         end
         ttsa_pkg::ST_ORTHO: begin
            for (int i = 0; i < 3; i++) begin
               pr_in[i] = fld(cur_ff, 5+i) * dot_ff;
            end
            state_in = ttsa_pkg::ST_ORTHO_SUB;
         end
         ttsa_pkg::ST_ORTHO_SUB: begin
            for (int i = 0; i < 3; i++) begin
               t = ttsa_pkg::sat32(66'(fld(cur_ff, (side_ff ? 11 : 8) + i))
                                   - fm(pr_ff[i]), f);
               cur_in[32*((side_ff ? 11 : 8) + i) +: 32] = t;
            end
            if (side_ff) begin
               state_in = ttsa_pkg::ST_ACC_WR;
            end else begin
               side_in = 1'b1;
               state_in = ttsa_pkg::ST_DOT;
            end
         end
         ttsa_pkg::ST_ACC_WR: begin
            we = 1'b1;
            waddr = idx_ff[k_ff];
            wdata = cur_ff;
            if (k_ff == 2'd2) begin
               k_in = '0;
               state_in = ttsa_pkg::ST_EMIT_RD;
            end else begin
               k_in = k_ff + 2'd1;
               state_in = ttsa_pkg::ST_ACC_RD;
            end
         end
         ttsa_pkg::ST_EMIT_RD: begin
            state_in = ttsa_pkg::ST_EMIT_LAT;
         end
         ttsa_pkg::ST_EMIT_LAT: begin
            cur_in = rd_data_ff;
            state_in = ttsa_pkg::ST_EMIT;
         end
         ttsa_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (op_ff == ttsa_pkg::OP_LOAD || op_ff == ttsa_pkg::OP_READ
                || k_ff == 2'd2) begin
               state_in = ttsa_pkg::ST_IDLE;
            end else begin
               k_in = k_ff + 2'd1;
               state_in = ttsa_pkg::ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ttsa_pkg::ST_IDLE;
         end
      endcase
      flag_in = f;
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      idx_ff <= idx_in;
      ra_ff <= ra_in; rb_ff <= rb_in; rc_ff <= rc_in; cur_ff <= cur_in;
      p1_ff <= p1_in; p2_ff <= p2_in;
      u1_ff <= u1_in; v1_ff <= v1_in; u2_ff <= u2_in; v2_ff <= v2_in;
      det_ff <= det_in;
      acc_ff <= acc_in;
      pr_ff <= pr_in;
      dot_ff <= dot_in;
      side_ff <= side_in;
      j_ff <= j_in;
      flag_ff <= flag_in;
      if (reset) begin
         state_ff <= ttsa_pkg::ST_IDLE;
         k_ff <= '0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
      end
   end

   assign rsp_vertex_id   = 10'(idx_ff[k_ff]);
   assign rsp_pos_unused  = 1'b0;
   assign rsp_tan_x   = fld(cur_ff, 8);
   assign rsp_tan_y   = fld(cur_ff, 9);
   assign rsp_tan_z   = fld(cur_ff, 10);
   assign rsp_bitan_x = fld(cur_ff, 11);
   assign rsp_bitan_y = fld(cur_ff, 12);
   assign rsp_bitan_z = fld(cur_ff, 13);
   assign rsp_norm_x  = fld(cur_ff, 5);
   assign rsp_norm_y  = fld(cur_ff, 6);
   assign rsp_norm_z  = fld(cur_ff, 7);
   assign rsp_degenerate  = flag_ff;
   assign rsp_last_of_run = (op_ff == ttsa_pkg::OP_LOAD || op_ff == ttsa_pkg::OP_READ
                             || k_ff == 2'd2);

   logic rsp_pos_unused;

   ap_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command not taken");
   ap_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("beat while idle");
   ap_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_of_run) |=> !busy)
      else $error("still busy after last beat");
   ap_no_write_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !we)
      else $error("memory write during beat");
endmodule

### bench/tangent_checker.sv
module tangent_checker
   import ttsa_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [9:0]         req_index_a,
   input  logic [9:0]         req_index_b,
   input  logic [9:0]         req_index_c,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_tex_u,
   input  logic signed [31:0] req_tex_v,
   input  logic signed [31:0] req_init_normal_x,
   input  logic signed [31:0] req_init_normal_y,
   input  logic signed [31:0] req_init_normal_z,
   input  logic               rsp_valid,
   input  logic [9:0]         rsp_vertex_id,
   input  logic signed [31:0] rsp_tan_x,
   input  logic signed [31:0] rsp_tan_y,
   input  logic signed [31:0] rsp_tan_z,
   input  logic signed [31:0] rsp_bitan_x,
   input  logic signed [31:0] rsp_bitan_y,
   input  logic signed [31:0] rsp_bitan_z,
   input  logic signed [31:0] rsp_norm_x,
   input  logic signed [31:0] rsp_norm_y,
   input  logic signed [31:0] rsp_norm_z,
   input  logic               rsp_degenerate,
   input  logic               rsp_last_of_run,
   output int                 mismatches,
   output int                 outstanding
);

   localparam int VERTS = 1024;
   localparam int FRAC  = 16;

   typedef struct {
      logic [9:0] id;
      int         tn[3];
      int         bt[3];
      int         nm[3];
      logic       deg;
      logic       last;
   } vertex_beat_t;

   int vpos[VERTS][3];
   int vtex[VERTS][2];
   int vnrm[VERTS][3];
   int vtan[VERTS][3];
   int vbit[VERTS][3];
   vertex_beat_t vertex_beats[$];
   bit sat_hit;
   int bad;

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) begin
         sat_hit = 1'b1;
         return 32'sh7fffffff;
      end
      if (v < -64'sd2147483648) begin
         sat_hit = 1'b1;
         return 32'sh80000000;
      end
      return int'(v);
   endfunction

   function automatic longint fixmul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FRAC;
   endfunction

   function automatic void accumulate(inout int t[3], input int s[3]);
      for (int i = 0; i < 3; i++) t[i] = clamp32(longint'(t[i]) + s[i]);
   endfunction

   function automatic void strip_normal(input int n[3], inout int v[3]);
      int d;
      d = clamp32(fixmul(n[0], v[0]) + fixmul(n[1], v[1]) + fixmul(n[2], v[2]));
      for (int i = 0; i < 3; i++) v[i] = clamp32(longint'(v[i]) - fixmul(n[i], d));
   endfunction

   function automatic void push_vertex(int id, logic deg, logic last);
      vertex_beat_t b;
      b.id = id[9:0];
      b.tn = vtan[id];
      b.bt = vbit[id];
      b.nm = vnrm[id];
      b.deg = deg;
      b.last = last;
      vertex_beats.push_back(b);
   endfunction

   function automatic void predict_command();
      int ids[3];
      int p1[3], p2[3], r[3], tg[3], bt[3], t0[3], n0[3];
      int u1, v1, u2, v2, det, nt, nb;
      op_type op;
      op = op_type'(req_operation);
      ids[0] = req_index_a % VERTS;
      ids[1] = req_index_b % VERTS;
      ids[2] = req_index_c % VERTS;
      sat_hit = 1'b0;
      if (op == OP_LOAD || op == OP_READ) begin
         if (op == OP_LOAD) begin
            vpos[ids[0]] = '{req_pos_x, req_pos_y, req_pos_z};
            vnrm[ids[0]] = '{req_init_normal_x, req_init_normal_y, req_init_normal_z};
            vtan[ids[0]] = '{0, 0, 0};
            vbit[ids[0]] = '{0, 0, 0};
            vtex[ids[0]] = '{req_tex_u, req_tex_v};
         end
         push_vertex(ids[0], 1'b0, 1'b1);
         return;
      end
      for (int i = 0; i < 3; i++) begin
         p1[i] = clamp32(longint'(vpos[ids[1]][i]) - vpos[ids[0]][i]);
         p2[i] = clamp32(longint'(vpos[ids[2]][i]) - vpos[ids[0]][i]);
      end
      if (op == OP_NORMAL) begin
         r[0] = clamp32(fixmul(p2[1], p1[2]) - fixmul(p2[2], p1[1]));
         r[1] = clamp32(fixmul(p2[2], p1[0]) - fixmul(p2[0], p1[2]));
         r[2] = clamp32(fixmul(p2[0], p1[1]) - fixmul(p2[1], p1[0]));
         for (int k = 0; k < 3; k++) begin
            t0 = vnrm[ids[k]];
            accumulate(t0, r);
            vnrm[ids[k]] = t0;
         end
      end else begin
         u1 = clamp32(longint'(vtex[ids[1]][0]) - vtex[ids[0]][0]);
         v1 = clamp32(longint'(vtex[ids[1]][1]) - vtex[ids[0]][1]);
         u2 = clamp32(longint'(vtex[ids[2]][0]) - vtex[ids[0]][0]);
         v2 = clamp32(longint'(vtex[ids[2]][1]) - vtex[ids[0]][1]);
         det = clamp32(fixmul(u1, v2) - fixmul(v1, u2));
         for (int i = 0; i < 3; i++) begin
            if (det == 0) begin
               tg[i] = 0;
               bt[i] = 0;
            end else begin
               nt = clamp32(fixmul(p1[i], v2) - fixmul(p2[i], v1));
               nb = clamp32(fixmul(p2[i], u1) - fixmul(p1[i], u2));
               tg[i] = clamp32((longint'(nt) <<< FRAC) / longint'(det));
               bt[i] = clamp32((longint'(nb) <<< FRAC) / longint'(det));
            end
         end
         if (det == 0) sat_hit = 1'b1;
         for (int k = 0; k < 3; k++) begin
            t0 = vtan[ids[k]];
            accumulate(t0, tg);
            vtan[ids[k]] = t0;
         end
         for (int k = 0; k < 3; k++) begin
            t0 = vbit[ids[k]];
            accumulate(t0, bt);
            vbit[ids[k]] = t0;
         end
         for (int k = 0; k < 3; k++) begin
            n0 = vnrm[ids[k]];
            t0 = vtan[ids[k]];
            strip_normal(n0, t0);
            vtan[ids[k]] = t0;
            t0 = vbit[ids[k]];
            strip_normal(n0, t0);
            vbit[ids[k]] = t0;
         end
      end
      for (int k = 0; k < 3; k++) push_vertex(ids[k], sat_hit, k == 2);
   endfunction

   always @(posedge clock) begin
      vertex_beat_t e;
      if (reset) begin
         vertex_beats.delete();
         for (int v = 0; v < VERTS; v++) begin
            vpos[v] = '{0, 0, 0};
            vnrm[v] = '{0, 0, 0};
            vtan[v] = '{0, 0, 0};
            vbit[v] = '{0, 0, 0};
            vtex[v] = '{0, 0};
         end
         bad = 0;
      end else begin
         if (rsp_valid) begin
            if (vertex_beats.size() == 0) begin
               bad++;
               if (bad <= 10) $display("unexpected beat: vertex %0d", rsp_vertex_id);
            end else begin
               e = vertex_beats.pop_front();
               if (e.id !== rsp_vertex_id || e.deg !== rsp_degenerate ||
                   e.last !== rsp_last_of_run ||
                   e.tn[0] !== rsp_tan_x || e.tn[1] !== rsp_tan_y || e.tn[2] !== rsp_tan_z ||
                   e.bt[0] !== rsp_bitan_x || e.bt[1] !== rsp_bitan_y ||
                   e.bt[2] !== rsp_bitan_z ||
                   e.nm[0] !== rsp_norm_x || e.nm[1] !== rsp_norm_y ||
                   e.nm[2] !== rsp_norm_z) begin
                  bad++;
                  if (bad <= 10) begin
                     $display("mismatch exp id=%0d t=%h %h %h b=%h %h %h n=%h %h %h d=%b l=%b",
                              e.id, e.tn[0], e.tn[1], e.tn[2], e.bt[0], e.bt[1], e.bt[2],
                              e.nm[0], e.nm[1], e.nm[2], e.deg, e.last);
                     $display("         got id=%0d t=%h %h %h b=%h %h %h n=%h %h %h d=%b l=%b",
                              rsp_vertex_id, rsp_tan_x, rsp_tan_y, rsp_tan_z,
                              rsp_bitan_x, rsp_bitan_y, rsp_bitan_z,
                              rsp_norm_x, rsp_norm_y, rsp_norm_z,
                              rsp_degenerate, rsp_last_of_run);
                  end
               end
            end
         end
         if (start && !busy) predict_command();
      end
      mismatches <= bad;
      outstanding <= vertex_beats.size();
   end

endmodule

### bench/tb_top.sv
module tb_top;
   import ttsa_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_operation = OP_READ;
   logic [9:0]         req_index_a = '0, req_index_b = '0, req_index_c = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic signed [31:0] req_tex_u = '0, req_tex_v = '0;
   logic signed [31:0] req_init_normal_x = '0, req_init_normal_y = '0;
   logic signed [31:0] req_init_normal_z = '0;
   logic               rsp_valid;
   logic [9:0]         rsp_vertex_id;
   logic signed [31:0] rsp_tan_x, rsp_tan_y, rsp_tan_z;
   logic signed [31:0] rsp_bitan_x, rsp_bitan_y, rsp_bitan_z;
   logic signed [31:0] rsp_norm_x, rsp_norm_y, rsp_norm_z;
   logic               rsp_degenerate, rsp_last_of_run;
   int                 mismatches, outstanding;

   localparam int SMAX = 32'sh7fffffff;
   localparam int SMIN = 32'sh80000000;
   localparam int ONE  = 65536;

   bit loaded[1024];
   int pool[$];
   int op_count[4];

   triangle_tangent_space_accumulator uut (.*);
   tangent_checker chk (.*);

   always #2 clock = ~clock;

   initial begin
      #4000000;
      $display("tb_top failed");
      $finish;
   end

   task automatic send_cmd(op_type op, int a, int b, int c, int px, int py, int pz,
                           int tu, int tv, int nx, int ny, int nz);
      req_operation <= op;
      req_index_a <= a[9:0];
      req_index_b <= b[9:0];
      req_index_c <= c[9:0];
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_tex_u <= tu;
      req_tex_v <= tv;
      req_init_normal_x <= nx;
      req_init_normal_y <= ny;
      req_init_normal_z <= nz;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      op_count[op]++;
      if (op == OP_LOAD && !loaded[a[9:0]]) begin
         loaded[a[9:0]] = 1'b1;
         pool.push_back(a[9:0]);
      end
   endtask

   task automatic hold_off();
      int r, n;
      r = $urandom_range(0, 99);
      n = (r < 50) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   function automatic int rand_fix();
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: case ($urandom_range(0, 2))
               0: return SMAX;
               1: return SMIN;
               default: return 0;
            endcase
         default: return int'($urandom_range(0, 1 << 22)) - (1 << 21);
      endcase
   endfunction

   function automatic int pick_vertex();
      return pool[$urandom_range(0, pool.size() - 1)];
   endfunction

   initial begin
      int a, b, c, r;
      op_type op;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_cmd(OP_LOAD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, ONE);
      send_cmd(OP_LOAD, 1023, 1023, 1023, ONE, 0, 0, ONE, 0, 0, 0, ONE);
      send_cmd(OP_LOAD, 512, 0, 0, 0, ONE, 0, 0, ONE, 0, 0, ONE);
      send_cmd(OP_TANGENT, 0, 1023, 512, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_NORMAL, 0, 1023, 512, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_LOAD, 5, 0, 0, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN, SMAX, SMIN);
      send_cmd(OP_LOAD, 6, 0, 0, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMAX, SMAX);
      send_cmd(OP_LOAD, 7, 0, 0, SMAX, SMIN, 0, SMIN, SMAX, ONE, -ONE, 0);
      send_cmd(OP_NORMAL, 5, 6, 7, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_TANGENT, 5, 6, 7, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_TANGENT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_TANGENT, 1023, 512, 1023, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_NORMAL, 6, 6, 5, 0, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(OP_READ, 5, 1023, 1023, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX, SMIN);
      send_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      hold_off();

      for (int n = 0; n < 250; n++) begin
         r = $urandom_range(0, 99);
         op = (r < 35) ? OP_LOAD : (r < 60) ? OP_NORMAL : (r < 88) ? OP_TANGENT : OP_READ;
         if (op == OP_LOAD)
            a = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 1023) : pick_vertex();
         else
            a = pick_vertex();
         if (op == OP_NORMAL || op == OP_TANGENT) begin
            b = pick_vertex();
            c = ($urandom_range(0, 9) == 0) ? a : pick_vertex();
         end else begin
            b = $urandom_range(0, 1023);
            c = $urandom_range(0, 1023);
         end
         send_cmd(op, a, b, c, rand_fix(), rand_fix(), rand_fix(), rand_fix(), rand_fix(),
                  rand_fix(), rand_fix(), rand_fix());
         if (n == 120) begin
            start <= 1'b0;
            do @(posedge clock); while (outstanding != 0);
         end else begin
            hold_off();
         end
      end
      start <= 1'b0;

      do @(posedge clock); while (outstanding != 0);
      repeat (40) @(posedge clock);
      $display("covered %0d loads, %0d normal, %0d tangent and %0d read commands",
               op_count[OP_LOAD], op_count[OP_NORMAL], op_count[OP_TANGENT],
               op_count[OP_READ]);
      $display("over %0d distinct vertices, %0d beats mismatched", pool.size(), mismatches);
      if (mismatches == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
